[rtl/core/llnsa_pkg.sv]
// shared types and constants for the least-loaded neighbor slot assigner
// no dependencies

package llnsa_pkg;

  // default sizing, the top level takes these as parameter defaults
  localparam int MAX_NODES_DEF      = 16;
  localparam int SLOTS_PER_NODE_DEF = 4;

  // fixed field widths
  localparam int CFG_W   = 5;
  localparam int NODE_W  = 4;
  localparam int SLOT_W  = 6;
  localparam int SIZE_W  = 32;
  localparam int CNT_W   = 16;
  localparam int BYTES_W = 48;
  localparam int SEQ_W   = 32;

  localparam logic [CNT_W-1:0]   CNT_MAX   = {CNT_W{1'b1}};
  localparam logic [BYTES_W-1:0] BYTES_MAX = {BYTES_W{1'b1}};

  // command codes
  localparam logic CMD_ASSIGN = 1'b0;
  localparam logic CMD_FLUSH  = 1'b1;

  // result kinds
  localparam logic KIND_ASSIGN = 1'b0;
  localparam logic KIND_REPORT = 1'b1;

  typedef enum logic [2:0] {
    S_IDLE,
    S_REDUCE,
    S_SCAN,
    S_DRAIN,
    S_UPDATE,
    S_FLUSH,
    S_FLUSH_END
  } state_t;

endpackage

[rtl/core/least_loaded_neighbor_slot_assigner_unit.sv]
// least-loaded neighbor slot assigner, top level
// holds the slot count/byte memories, the scan sequencer and the result registers
// depends on llnsa_pkg
//
//   channel   signals                                  handshake
//   -------   --------------------------------------   -------------------------------
//   item in   start, busy, cmd, host_node, chunk_len   taken when start && !busy
//   result    result_strobe, kind, slot, node,         one cycle per result, strobed,
//             chunk_count, byte_total, seq, last       receiver cannot hold off
//   config    cfg_valid, cfg_ready, cfg_data           written when cfg_valid && cfg_ready
//
// an assign item runs the home reduction (one subtract per cycle until host_node is below
//   the ring size), then one compare per candidate slot through the single comparator,
//   then a drain and an update state
// a flush item reads every slot of the nodes in use, one report per cycle,
//   set by the single read port of the slot memories
// the result strobe is registered; busy is already low then for an item's last result
// reset: synchronous, clears ring size to 1, sequence number and all slot valid bits;
//   slots not valid read as zero, so no clearing pass is needed
// a flush clears all valid bits at once when its last report goes out

module least_loaded_neighbor_slot_assigner_unit
  import llnsa_pkg::*;
#(
  parameter int MAX_NODES      = MAX_NODES_DEF,
  parameter int SLOTS_PER_NODE = SLOTS_PER_NODE_DEF
) (
  input  logic               clk,
  input  logic               rst,

  // item in
  input  logic               start,
  output logic               busy,
  input  logic               cmd,
  input  logic [NODE_W-1:0]  host_node,
  input  logic [SIZE_W-1:0]  chunk_len,

  // results
  output logic               result_strobe,
  output logic               kind,
  output logic [SLOT_W-1:0]  slot,
  output logic [NODE_W-1:0]  node,
  output logic [CNT_W-1:0]   chunk_count,
  output logic [BYTES_W-1:0] byte_total,
  output logic [SEQ_W-1:0]   seq,
  output logic               last,

  // ring size register
  input  logic               cfg_valid,
  output logic               cfg_ready,
  input  logic [CFG_W-1:0]   cfg_data
);

  localparam int NSLOTS = MAX_NODES * SLOTS_PER_NODE;
  localparam int AW     = (NSLOTS > 1) ? $clog2(NSLOTS) : 1;
  localparam int CW     = (SLOTS_PER_NODE > 1) ? $clog2(SLOTS_PER_NODE) : 1;
  localparam logic [CW-1:0] CORE_LAST = CW'(SLOTS_PER_NODE - 1);

  state_t state, state_next;

  // ring size, kept already clamped to 1..MAX_NODES
  logic [CFG_W-1:0]   ring_n;
  logic [CFG_W-1:0]   ring_wr;

  // item registers
  logic [NODE_W-1:0]  home;
  logic [SIZE_W-1:0]  size_q;

  // sequencer counters
  logic [1:0]         nb_idx;
  logic [CW-1:0]      core;
  logic [NODE_W-1:0]  fnode;

  // slot memories, valid bits stand in for the all-zero reset
  logic [CNT_W-1:0]   count_mem [NSLOTS];
  logic [BYTES_W-1:0] bytes_mem [NSLOTS];
  logic [NSLOTS-1:0]  slot_valid;

  // read pipeline
  logic               issue;
  logic [AW-1:0]      rd_addr;
  logic [NODE_W-1:0]  rd_node;
  logic               pend;
  logic [AW-1:0]      pend_slot;
  logic [NODE_W-1:0]  pend_node;
  logic               pend_last;
  logic [CNT_W-1:0]   mem_cnt_q;
  logic [BYTES_W-1:0] mem_bytes_q;
  logic               mem_vld_q;
  logic [CNT_W-1:0]   cand_cnt;
  logic [BYTES_W-1:0] cand_bytes;

  // running best candidate
  logic               best_set;
  logic [AW-1:0]      best_slot;
  logic [NODE_W-1:0]  best_node;
  logic [CNT_W-1:0]   best_cnt;
  logic [BYTES_W-1:0] best_bytes;

  logic [SEQ_W-1:0]   next_seq;

  // misc decode
  logic               home_ge;
  logic [NODE_W-1:0]  last_node;
  logic [NODE_W-1:0]  prev_node;
  logic [NODE_W-1:0]  succ_node;
  logic               scan_end;
  logic               flush_end;
  logic               do_cmp;
  logic               do_rep;
  logic               mem_we;
  logic [CNT_W-1:0]   cnt_new;
  logic [BYTES_W:0]   bytes_sum;
  logic [BYTES_W-1:0] bytes_new;

  assign busy      = (state != S_IDLE);
  assign cfg_ready = (state == S_IDLE);

  // clamp on write: zero acts as one, too large acts as the full ring
  always_comb begin
    if (cfg_data == '0) begin
      ring_wr = CFG_W'(1);
    end else if (cfg_data > CFG_W'(MAX_NODES)) begin
      ring_wr = CFG_W'(MAX_NODES);
    end else begin
      ring_wr = cfg_data;
    end
  end

  // neighborhood with wrap-around over the nodes in use
  assign home_ge   = ({1'b0, home} >= ring_n);
  assign last_node = NODE_W'(ring_n - CFG_W'(1));
  assign prev_node = (home == '0) ? last_node : home - NODE_W'(1);
  assign succ_node = (({1'b0, home} + CFG_W'(1)) >= ring_n) ? '0 : home + NODE_W'(1);

  assign scan_end  = (nb_idx == 2'd2) && (core == CORE_LAST);
  assign flush_end = (fnode == last_node) && (core == CORE_LAST);

  // empty slots read as zero
  assign cand_cnt   = mem_vld_q ? mem_cnt_q : '0;
  assign cand_bytes = mem_vld_q ? mem_bytes_q : '0;

  // saturating bump of the winner
  assign cnt_new   = (best_cnt == CNT_MAX) ? best_cnt : best_cnt + CNT_W'(1);
  assign bytes_sum = {1'b0, best_bytes} + (BYTES_W + 1)'(size_q);
  assign bytes_new = bytes_sum[BYTES_W] ? BYTES_MAX : bytes_sum[BYTES_W-1:0];

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    issue      = 1'b0;
    mem_we     = 1'b0;
    do_cmp     = 1'b0;
    do_rep     = 1'b0;
    unique case (state)
      S_IDLE: begin
        if (start) begin
          state_next = (cmd == CMD_FLUSH) ? S_FLUSH : S_REDUCE;
        end
      end
      S_REDUCE: begin
        if (!home_ge) begin
          state_next = S_SCAN;
        end
      end
      S_SCAN: begin
        issue  = 1'b1;
        do_cmp = pend;
        if (scan_end) begin
          state_next = S_DRAIN;
        end
      end
      S_DRAIN: begin
        do_cmp     = pend;
        state_next = S_UPDATE;
      end
      S_UPDATE: begin
        mem_we     = 1'b1;
        state_next = S_IDLE;
      end
      S_FLUSH: begin
        issue  = 1'b1;
        do_rep = pend;
        if (flush_end) begin
          state_next = S_FLUSH_END;
        end
      end
      S_FLUSH_END: begin
        do_rep     = pend;
        state_next = S_IDLE;
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

  // candidate node: previous, home, next in that order
  always_comb begin
    if (state == S_FLUSH) begin
      rd_node = fnode;
    end else if (nb_idx == 2'd0) begin
      rd_node = prev_node;
    end else if (nb_idx == 2'd1) begin
      rd_node = home;
    end else begin
      rd_node = succ_node;
    end
    rd_addr = AW'(int'(rd_node) * SLOTS_PER_NODE + int'(core));
  end

  // slot memories: one write port, one registered read port
  always_ff @(posedge clk) begin
    if (mem_we) begin
      count_mem[best_slot] <= cnt_new;
      bytes_mem[best_slot] <= bytes_new;
    end
    if (issue) begin
      mem_cnt_q   <= count_mem[rd_addr];
      mem_bytes_q <= bytes_mem[rd_addr];
      mem_vld_q   <= slot_valid[rd_addr];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      ring_n        <= CFG_W'(1);
      slot_valid    <= '0;
      next_seq      <= '0;
      result_strobe <= 1'b0;
      pend          <= 1'b0;
    end else begin
      result_strobe <= mem_we || do_rep;
      pend          <= issue;

      if (cfg_valid && cfg_ready) begin
        ring_n <= ring_wr;
      end

      if (issue) begin
        pend_slot <= rd_addr;
        pend_node <= rd_node;
        pend_last <= flush_end;
      end

      // item capture
      if (state == S_IDLE && start) begin
        home     <= host_node;
        size_q   <= chunk_len;
        nb_idx   <= 2'd0;
        core     <= '0;
        fnode    <= '0;
        best_set <= 1'b0;
      end

      // home node reduction, one subtract per cycle
      if (state == S_REDUCE && home_ge) begin
        home <= home - NODE_W'(ring_n);
      end

      // candidate walk
      if (state == S_SCAN) begin
        if (core == CORE_LAST) begin
          core   <= '0;
          nb_idx <= nb_idx + 2'd1;
        end else begin
          core <= core + CW'(1);
        end
      end

      // flush walk
      if (state == S_FLUSH) begin
        if (core == CORE_LAST) begin
          core  <= '0;
          fnode <= fnode + NODE_W'(1);
        end else begin
          core <= core + CW'(1);
        end
      end

      // shared comparator, strict less so the earliest minimum stays
      if (do_cmp && (!best_set || cand_cnt < best_cnt)) begin
        best_set   <= 1'b1;
        best_slot  <= pend_slot;
        best_node  <= pend_node;
        best_cnt   <= cand_cnt;
        best_bytes <= cand_bytes;
      end

      // assignment result
      if (mem_we) begin
        slot_valid[best_slot] <= 1'b1;
        kind                  <= KIND_ASSIGN;
        slot                  <= SLOT_W'(best_slot);
        node                  <= best_node;
        chunk_count           <= cnt_new;
        byte_total            <= bytes_new;
        seq                   <= '0;
        last                  <= 1'b1;
      end

      // flush report
      if (do_rep) begin
        kind          <= KIND_REPORT;
        slot          <= SLOT_W'(pend_slot);
        node          <= pend_node;
        chunk_count   <= cand_cnt;
        byte_total    <= cand_bytes;
        seq           <= next_seq;
        last          <= pend_last;
        next_seq      <= next_seq + SEQ_W'(1);
      end

      // last report read out, drop every slot at once
      if (state == S_FLUSH_END) begin
        slot_valid <= '0;
      end
    end
  end

endmodule
